>>> sv/mt_pkg.sv
// Shared types and constants for the MT19937 generator.
package mt_pkg;

  localparam int unsigned StateWords  = 624;
  localparam int unsigned ShiftOffset = 397;
  localparam int unsigned AddrW       = 10;
  localparam int unsigned QDepth      = 2;

  localparam logic [31:0] TwistMatrix = 32'h9908b0df;
  localparam logic [31:0] HighBit     = 32'h80000000;
  localparam logic [31:0] LowBits     = 32'h7fffffff;
  localparam logic [31:0] TemperB     = 32'h9d2c5680;
  localparam logic [31:0] TemperC     = 32'hefc60000;
  localparam logic [31:0] SeedMult    = 32'd1812433253;

  localparam logic [1:0] FuncSeed = 2'd0;
  localparam logic [1:0] FuncNext = 2'd1;
  localparam logic [1:0] FuncSkip = 2'd2;

  localparam logic [AddrW-1:0] LastWord = AddrW'(StateWords - 1);
  localparam logic [AddrW-1:0] EndPos   = AddrW'(StateWords);

  // One classified request handed from the front end to the engine.
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] seed_value;
    logic [16:0] skip_count;
  } req_t;

  function automatic logic [31:0] temper(input logic [31:0] v_in);
    logic [31:0] v;
    v = v_in;
    v = v ^ (v >> 11);
    v = v ^ ((v << 7) & TemperB);
    v = v ^ ((v << 15) & TemperC);
    v = v ^ (v >> 18);
    return v;
  endfunction

endpackage

>>> sv/mt_front.sv
// Input front end: unpacks requests and buffers them in a short queue.
module mt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [55:0]        s_axis_tdata,
  output logic               req_valid_o,
  input  logic               req_ready_i,
  output mt_pkg::req_t       req_o
);

  mt_pkg::req_t fifo_q [mt_pkg::QDepth];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;
  logic         push, pop;

  assign s_axis_tready = (count_q != 2'(mt_pkg::QDepth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign req_valid_o   = (count_q != 2'd0);
  assign pop           = req_valid_o && req_ready_i;
  assign req_o         = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].func       <= s_axis_tdata[1:0];
      fifo_q[wr_ptr_q].seed_value <= s_axis_tdata[33:2];
      fifo_q[wr_ptr_q].skip_count <= s_axis_tdata[50:34];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(mt_pkg::QDepth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> count_q != 2'd0) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 2'd1) else $error("bad count");
`endif

endmodule

>>> sv/mt_engine.sv
// Back end: state memory, seeding, twist, tempering and position control.
module mt_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  output logic         req_ready_o,
  input  mt_pkg::req_t req_i,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata
);

  localparam int AW = mt_pkg::AddrW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSeed  = 4'd1;
  localparam logic [3:0] StSeedM = 4'd2;
  localparam logic [3:0] StTwA   = 4'd3;
  localparam logic [3:0] StTwB   = 4'd4;
  localparam logic [3:0] StTwC   = 4'd5;
  localparam logic [3:0] StRead  = 4'd6;
  localparam logic [3:0] StTemp  = 4'd7;
  localparam logic [3:0] StDone  = 4'd8;
  localparam logic [3:0] StClear = 4'd9;

  logic [31:0]   mem [mt_pkg::StateWords];
  logic [31:0]   rdata_q;
  logic [AW-1:0] raddr;
  logic          re;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          we;

  logic [3:0]    st_q, st_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] k_q, k_d;
  logic [31:0]   prev_q, prev_d;
  logic [31:0]   cur_q, cur_d;
  logic [31:0]   prod_q, prod_d;
  logic [16:0]   left_q, left_d;
  logic [1:0]    func_q, func_d;
  logic [31:0]   out_val_q, out_val_d;
  logic          out_clamp_q, out_clamp_d;
  logic          ovalid_q, ovalid_d;
  logic          after_q, after_d;

  logic [AW-1:0] knext, kfar;
  logic [31:0]   y_w, tw_w;
  logic [16:0]   back_w;
  logic [17:0]   sum_w;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  assign knext = (k_q == mt_pkg::LastWord) ? '0 : k_q + 1'b1;
  assign kfar  = (k_q >= AW'(mt_pkg::StateWords - mt_pkg::ShiftOffset))
               ? k_q - AW'(mt_pkg::StateWords - mt_pkg::ShiftOffset)
               : k_q + AW'(mt_pkg::ShiftOffset);
  assign y_w   = (cur_q & mt_pkg::HighBit) | (prev_q & mt_pkg::LowBits);
  assign tw_w  = rdata_q ^ (y_w >> 1) ^ (y_w[0] ? mt_pkg::TwistMatrix : 32'd0);
  assign back_w = 17'(-req_i.skip_count);
  assign sum_w  = 18'(pos_q) + 18'(req_i.skip_count[15:0]);

  assign req_ready_o  = (st_q == StIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, out_clamp_q, out_val_q};

  always_comb begin
    st_d = st_q; pos_d = pos_q; k_d = k_q; prev_d = prev_q; cur_d = cur_q;
    prod_d = prod_q; left_d = left_q; func_d = func_q; out_val_d = out_val_q;
    out_clamp_d = out_clamp_q; ovalid_d = ovalid_q; after_d = after_q;
    re = 1'b0; raddr = k_q; we = 1'b0; waddr = k_q; wdata = cur_q;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (st_q)
      StClear: begin
        we = 1'b1; wdata = '0;
        k_d = knext;
        if (k_q == mt_pkg::LastWord) st_d = StIdle;
      end
      StIdle: begin
        if (req_valid_i && req_ready_o) begin
          func_d = req_i.func;
          out_val_d = '0; out_clamp_d = 1'b0;
          case (req_i.func)
            mt_pkg::FuncSeed: begin
              we = 1'b1; waddr = '0; wdata = req_i.seed_value;
              prev_d = req_i.seed_value; k_d = AW'(1);
              st_d = StSeedM;
            end
            mt_pkg::FuncNext: begin
              if (pos_q >= mt_pkg::EndPos) begin
                pos_d = '0; k_d = '0; after_d = 1'b1;
                re = 1'b1; raddr = '0; st_d = StTwA;
              end else begin
                re = 1'b1; raddr = pos_q; st_d = StRead;
              end
            end
            mt_pkg::FuncSkip: begin
              if (req_i.skip_count[16]) begin
                if (back_w > 17'(pos_q)) begin
                  pos_d = '0; out_clamp_d = 1'b1;
                end else begin
                  pos_d = pos_q - back_w[AW-1:0];
                end
                st_d = StDone;
              end else if (sum_w >= 18'(mt_pkg::StateWords)) begin
                left_d = 17'(sum_w - 18'(mt_pkg::StateWords));
                k_d = '0; after_d = 1'b0;
                re = 1'b1; raddr = '0; st_d = StTwA;
              end else begin
                pos_d = sum_w[AW-1:0]; st_d = StDone;
              end
            end
            default: st_d = StDone;
          endcase
        end
      end
      StSeedM: begin
        prod_d = mt_pkg::SeedMult * (prev_q ^ (prev_q >> 30));
        st_d = StSeed;
      end
      StSeed: begin
        we = 1'b1; wdata = prod_q + 32'(k_q);
        prev_d = wdata;
        k_d = knext;
        if (k_q == mt_pkg::LastWord) begin
          pos_d = mt_pkg::EndPos; st_d = StDone;
        end else st_d = StSeedM;
      end
      // Twist: read word k, then word k+1, then word k+397, then write.
      StTwA: begin
        cur_d = rdata_q; re = 1'b1; raddr = knext; st_d = StTwB;
      end
      StTwB: begin
        prev_d = rdata_q; re = 1'b1; raddr = kfar; st_d = StTwC;
      end
      StTwC: begin
        we = 1'b1; wdata = tw_w;
        k_d = knext;
        if (k_q == mt_pkg::LastWord) begin
          if (after_q) begin
            re = 1'b1; raddr = pos_q; st_d = StRead;
          end else if (left_q >= 17'(mt_pkg::StateWords)) begin
            left_d = left_q - 17'(mt_pkg::StateWords);
            re = 1'b1; raddr = '0; st_d = StTwA;
          end else begin
            pos_d = left_q[AW-1:0]; st_d = StDone;
          end
        end else begin
          re = 1'b1; raddr = knext; st_d = StTwA;
        end
      end
      StRead: st_d = StTemp;
      StTemp: begin
        out_val_d = mt_pkg::temper(rdata_q);
        pos_d = pos_q + 1'b1;
        st_d = StDone;
      end
      StDone: begin
        ovalid_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; pos_q <= mt_pkg::EndPos; k_q <= '0;
      ovalid_q <= 1'b0; after_q <= 1'b0; func_q <= mt_pkg::FuncSeed;
    end else begin
      st_q <= st_d; pos_q <= pos_d; k_q <= k_d;
      ovalid_q <= ovalid_d; after_q <= after_d; func_q <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d; cur_q <= cur_d; prod_q <= prod_d; left_q <= left_d;
    out_val_q <= out_val_d; out_clamp_q <= out_clamp_d;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mt_pkg::EndPos) else $error("position out of range");
  a_val_only_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) && func_q != mt_pkg::FuncNext |-> out_val_q == 32'd0)
    else $error("nonzero value for non-next request");
  a_clamp_only_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) && out_clamp_q |-> func_q == mt_pkg::FuncSkip)
    else $error("clamp on non-skip request");
`endif

endmodule

>>> sv/mt19937_generator.sv
// Top level of the MT19937 generator: request queue plus twister engine.
// This block is a 32-bit MT19937 generator holding its 624-word state in a
// memory with one read port and one write port. Each request yields exactly
// one response. After reset the block clears the state memory to zero
// before it takes requests. A seed request does a registered multiply and a
// write per word. A next request reads and tempers one word; when a twist is
// due it first regenerates the block, reading three words and writing one
// for each of the 624 words. A forward skip runs one twist per block
// boundary crossed; a backward skip clamps at position zero, reporting that
// in the clamped bit. One request is worked on at a time; a two-entry input
// queue lets the sender run ahead.
module mt19937_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: func[1:0], seed_value[33:2], skip_count[50:34].
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: random_value[31:0], clamped[32].
  output logic [39:0] m_axis_tdata
);

  logic         req_valid;
  logic         req_ready;
  mt_pkg::req_t req;

  // The front queue decouples the sender from the long-running engine.
  mt_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  // The engine performs seeding, twisting and tempering.
  mt_engine u_engine (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

>>> sim/tb_mt19937_generator.sv
// Self-checking testbench for the MT19937 generator stream block.
`timescale 1ns / 1ps

module tb_mt19937_generator;

  // The fourth operation code is unused and must leave the state alone.
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int         NumWords   = 624;

  typedef struct {
    logic [31:0] random_value;
    logic        clamped;
  } gen_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // Fields from bit 0: func[1:0], seed_value[33:2], skip_count[50:34].
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // Fields from bit 0: random_value[31:0], clamped[32].
  logic [39:0] m_axis_tdata;

  // Predicted generator state, advanced once per accepted request.
  logic [31:0] gen_words [NumWords];
  int unsigned gen_pos;

  gen_result_t pending_results [$];
  int          err_count;
  int          req_count;
  int          resp_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          recv_hold;

  mt19937_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Regenerate the whole state block in place, as the standard twist does.
  function automatic void twist_block();
    logic [31:0] y;
    for (int k = 0; k < NumWords; k++) begin
      y = (gen_words[k] & 32'h80000000) | (gen_words[(k + 1) % NumWords] & 32'h7fffffff);
      gen_words[k] = gen_words[(k + 397) % NumWords] ^ (y >> 1) ^
                     (y[0] ? 32'h9908b0df : 32'h0);
    end
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & 32'h9d2c5680);
    t = t ^ ((t << 15) & 32'hefc60000);
    return t ^ (t >> 18);
  endfunction

  // Work out the single result of one request and advance the predicted state.
  function automatic gen_result_t predict_request(input logic [1:0] func,
                                                  input logic [31:0] seed,
                                                  input logic [16:0] skip);
    gen_result_t r;
    logic [31:0] p;
    int unsigned back;
    r.random_value = '0;
    r.clamped      = 1'b0;
    case (func)
      mt_pkg::FuncSeed: begin
        gen_words[0] = seed;
        for (int i = 1; i < NumWords; i++) begin
          p = gen_words[i - 1];
          gen_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
        end
        gen_pos = NumWords;
      end
      mt_pkg::FuncNext: begin
        if (gen_pos >= NumWords) begin
          twist_block();
          gen_pos = 0;
        end
        r.random_value = temper_word(gen_words[gen_pos]);
        gen_pos++;
      end
      mt_pkg::FuncSkip: begin
        if (skip[16]) begin
          // Backward step; the magnitude runs from 1 to 65536.
          back = 32'h20000 - 32'(skip);
          if (back > gen_pos) begin
            gen_pos   = 0;
            r.clamped = 1'b1;
          end else begin
            gen_pos -= back;
          end
        end else begin
          gen_pos += 32'(skip);
          while (gen_pos >= NumWords) begin
            gen_pos -= NumWords;
            twist_block();
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request, with random gaps first, and record its expected result
  // once the block takes it.
  task automatic send_request(input logic [1:0] func, input logic [31:0] seed,
                              input logic [16:0] skip);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, skip, seed, func};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_request(func, seed, skip));
    req_count++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Receiver readiness, redrawn every cycle unless held off.
  always @(negedge clk_i) begin
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each delivered response with the oldest expectation.
  always @(posedge clk_i) begin
    gen_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      resp_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected response, random_value %h", m_axis_tdata[31:0]);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.random_value) begin
          $error("random_value expected %h actual %h", want.random_value,
                 m_axis_tdata[31:0]);
          err_count++;
        end
        if (m_axis_tdata[32] !== want.clamped) begin
          $error("clamped expected %b actual %b", want.clamped, m_axis_tdata[32]);
          err_count++;
        end
      end
    end
  end

  // Directed cases: unseeded outputs, seed extremes, the unused code and the
  // position edge cases of skips.
  task automatic test_directed();
    send_request(mt_pkg::FuncNext, '0, '0);           // zero store twists to zero
    send_request(mt_pkg::FuncNext, '0, '0);
    send_request(FuncUnused, 32'hffffffff, 17'h1ffff);
    send_request(mt_pkg::FuncSeed, 32'd5489, '0);
    repeat (3) send_request(mt_pkg::FuncNext, '0, '0);
    send_request(mt_pkg::FuncSkip, '0, 17'd0);        // skip of zero
    send_request(mt_pkg::FuncSeed, 32'h0, '0);
    send_request(mt_pkg::FuncSkip, '0, -17'sd1);      // step back from block end
    send_request(mt_pkg::FuncNext, '0, '0);
    send_request(mt_pkg::FuncSkip, '0, -17'sd624);
    send_request(mt_pkg::FuncNext, '0, '0);
    send_request(mt_pkg::FuncSkip, '0, -17'sd5);      // past zero, clamps
    send_request(mt_pkg::FuncSeed, 32'hffffffff, '0);
    send_request(mt_pkg::FuncSkip, '0, 17'h10000);    // most negative count
    send_request(mt_pkg::FuncSkip, '0, 17'd623);
    send_request(mt_pkg::FuncNext, '0, '0);
    send_request(mt_pkg::FuncNext, '0, '0);           // crosses a block boundary
    send_request(mt_pkg::FuncSkip, '0, 17'hffff);     // largest forward count
    send_request(mt_pkg::FuncNext, '0, '0);
    wait_drained();
  endtask

  // Random traffic, mostly outputs with some skips, seeds and unused codes.
  task automatic test_random(input int count);
    int sel;
    logic [16:0] skip;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 74) begin
        send_request(mt_pkg::FuncNext, $urandom, 17'($urandom));
      end else if (sel < 84) begin
        skip = ($urandom_range(3) == 0) ? 17'($urandom_range(1400)) :
                                          17'($urandom_range(40));
        send_request(mt_pkg::FuncSkip, $urandom, skip);
      end else if (sel < 93) begin
        skip = ($urandom_range(3) == 0) ? 17'h10000 | 17'($urandom) :
                                          -17'($urandom_range(700, 1));
        send_request(mt_pkg::FuncSkip, $urandom, skip);
      end else if (sel < 97) begin
        send_request(mt_pkg::FuncSeed, $urandom, 17'($urandom));
      end else begin
        send_request(FuncUnused, $urandom, 17'($urandom));
      end
    end
  endtask

  // Hold the receiver off long enough that the input queue fills and stalls.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      repeat (8) send_request(mt_pkg::FuncNext, $urandom, '0);
    join
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    recv_hold     = 1'b0;
    err_count     = 0;
    req_count     = 0;
    resp_count    = 0;
    send_idle_pct = 17;
    recv_idle_pct = 87;
    for (int i = 0; i < NumWords; i++) gen_words[i] = '0;
    gen_pos = NumWords;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(200);
    wait_drained();
    send_idle_pct = 87;
    recv_idle_pct = 17;
    test_random(200);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(220);
    wait_drained();

    $display("Covered %0d requests and %0d responses: seeds, outputs, skips both ways,",
             req_count, resp_count);
    $display("clamping, unused codes and a long receiver stall under three idle mixes.");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
sv/mt_pkg.sv
sv/mt_front.sv
sv/mt_engine.sv
sv/mt19937_generator.sv
sim/tb_mt19937_generator.sv
